### rtl/gmag_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gmag_pkg;

  // cell and result field widths
  localparam int DIST_BITS  = 12;
  localparam int IN_W       = DIST_BITS + 1;
  localparam int GRAD_W     = DIST_BITS + 3;
  localparam int ABS_W      = GRAD_W - 1;
  localparam int SQ_W       = 2 * ABS_W;
  localparam int MAG_W      = DIST_BITS + 7;
  localparam int POS_W      = 12;
  localparam int CFG_W      = 13;
  localparam int ROW_W      = 13;
  localparam int MAX_HEIGHT = 4096;

  // radicand is 256 * (gx^2 + gy^2)
  localparam int RAD_W      = SQ_W + 1 + 8;
  localparam int SQ_STEPS   = (RAD_W + 1) / 2;
  localparam int SQ_CNT_W   = $clog2(SQ_STEPS + 1);

  // configuration register indexes
  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;

  // handshake between the sequencer and the root unit
  typedef struct packed {
    logic start;
    logic [RAD_W-1:0] radicand;
  } sqrt_req_t;

endpackage

`default_nettype wire

### rtl/gmag_line_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module gmag_line_mem #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 26
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/gmag_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module gmag_sqrt (
  input  wire                     clk,
  input  wire                     rst,
  input  wire gmag_pkg::sqrt_req_t req,
  output logic                    done,
  output logic [gmag_pkg::MAG_W-1:0] root
);

  import gmag_pkg::*;

  logic [RAD_W-1:0]    rem;
  logic [RAD_W-1:0]    res;
  logic [RAD_W-1:0]    bitv;
  logic [SQ_CNT_W-1:0] cnt;
  logic [RAD_W-1:0]    trial;

  // one result bit per cycle, restoring form
  assign trial = res + bitv;
  assign root  = res[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= req.radicand;
        res  <= '0;
        bitv <= RAD_W'(1) << (2 * (SQ_STEPS - 1));
        cnt  <= SQ_CNT_W'(SQ_STEPS);
      end else if (cnt != '0) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt - SQ_CNT_W'(1);
        if (cnt == SQ_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/grid_gradient_magnitude_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | dir | handshake          | payload
// ----------+-----+--------------------+----------------------------------------------
// s_*       | in  | s_tvalid/s_tready  | tdata: cell_distance; tuser: first_of_map
// m_*       | out | m_tvalid/m_tready  | tdata: col,row,gx,gy,mag; tuser: mag valid;
//           |     |                    | tlast: last_of_map
// cfg_*     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// one cell in flight at a time: a cell giving no result passes accept and the
// line store read/write; an interior cell passes accept, line store, window
// sums, squares, radicand, the wait on the bit-serial square root (19 root bits
// and then done) and the output load.
// after rst the line stores are zeroed by a pass over all MAX_WIDTH addresses; no
// cell is taken in that time. the result register lets the next cell enter while
// a finished transaction waits on m_tready.

module grid_gradient_magnitude_core #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire         clk,
  input  wire         rst,
  // cell stream
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // [12:0] cell_distance, rest zero
  input  wire         s_tuser,   // [0] first_of_map
  // result stream
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [79:0] m_tdata,   // [11:0] centre_col, [23:12] centre_row,
                                 // [38:24] grad_horizontal, [53:39] grad_vertical,
                                 // [72:54] magnitude_q4, rest zero
  output logic        m_tuser,   // [0] magnitude_valid
  output logic        m_tlast,   // last_of_map
  // configuration writes
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [12:0] cfg_data
);

  import gmag_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (CW > CFG_W) ? CW : CFG_W;
  localparam int MW = 2 * IN_W;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_GRAD, S_SQ, S_SUM, S_SQRT, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [CFG_W-1:0] map_width;
  logic [CFG_W-1:0] map_height;
  logic [WW-1:0]    eff_w;
  logic [ROW_W-1:0] eff_h;

  // position counters, next cell
  logic [WW-1:0]    col_cnt;
  logic [ROW_W-1:0] row_cnt;

  // current cell
  logic signed [IN_W-1:0] cell_v;
  logic [AW-1:0]          cur_addr;
  logic                   has_result;
  logic [POS_W-1:0]       ctr_col;
  logic [POS_W-1:0]       ctr_row;
  logic                   last_flag;

  logic signed [IN_W-1:0] win [9];

  logic signed [GRAD_W-1:0] gx;
  logic signed [GRAD_W-1:0] gy;
  logic                     centre_ok;
  logic [SQ_W-1:0]          sqx;
  logic [SQ_W-1:0]          sqy;

  logic [AW-1:0] clr_addr;

  // memory
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;
  logic [MW-1:0] mem_rdata;

  sqrt_req_t        sq_req;
  logic             sq_done;
  logic [MAG_W-1:0] sq_root;

  // position of the arriving cell
  logic [WW-1:0]    c0;
  logic [WW-1:0]    c;
  logic [WW-1:0]    c_inc;
  logic [ROW_W-1:0] r0;
  logic [ROW_W-1:0] r1;
  logic [ROW_W-1:0] r;
  logic [ROW_W-1:0] r_inc;
  logic [WW-1:0]    col_next;
  logic [ROW_W-1:0] row_next;
  logic signed [IN_W-1:0] in_v;
  logic             accept;

  logic signed [IN_W-1:0] top_v;
  logic signed [IN_W-1:0] mid_v;
  logic signed [GRAD_W-1:0] gx_c;
  logic signed [GRAD_W-1:0] gy_c;
  logic [ABS_W-1:0]         ax;
  logic [ABS_W-1:0]         ay;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;

  // clamp the size registers
  always_comb begin
    eff_w = WW'(map_width);
    if (eff_w < WW'(3)) eff_w = WW'(3);
    if (eff_w > WW'(MAX_WIDTH)) eff_w = WW'(MAX_WIDTH);
    eff_h = map_height;
    if (eff_h < ROW_W'(3)) eff_h = ROW_W'(3);
    if (eff_h > ROW_W'(MAX_HEIGHT)) eff_h = ROW_W'(MAX_HEIGHT);
  end

  // any negative cell is an obstacle
  assign in_v = s_tdata[IN_W-1] ? -IN_W'(1) : $signed(s_tdata[IN_W-1:0]);

  always_comb begin
    c0 = s_tuser ? '0 : col_cnt;
    r0 = s_tuser ? '0 : row_cnt;
    if (c0 >= eff_w) begin
      c  = '0;
      r1 = r0 + ROW_W'(1);
    end else begin
      c  = c0;
      r1 = r0;
    end
    r = (r1 >= eff_h) ? '0 : r1;
    c_inc = c + WW'(1);
    r_inc = r + ROW_W'(1);
    if (c_inc >= eff_w) begin
      col_next = '0;
      row_next = (r_inc >= eff_h) ? '0 : r_inc;
    end else begin
      col_next = c_inc;
      row_next = r;
    end
  end

  // line store word: upper half previous row, lower half the row before
  assign top_v = $signed(mem_rdata[IN_W-1:0]);
  assign mid_v = $signed(mem_rdata[MW-1:IN_W]);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = {cell_v, mid_v};
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (state == S_READ) begin
      mem_we = 1'b1;
    end
  end

  gmag_line_mem #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (MW)
  ) u_line_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (c[AW-1:0]),
    .rdata (mem_rdata)
  );

  // prewitt sums over the settled window
  assign gx_c = (GRAD_W'(win[2]) + GRAD_W'(win[5]) + GRAD_W'(win[8]))
              - (GRAD_W'(win[0]) + GRAD_W'(win[3]) + GRAD_W'(win[6]));
  assign gy_c = (GRAD_W'(win[0]) + GRAD_W'(win[1]) + GRAD_W'(win[2]))
              - (GRAD_W'(win[6]) + GRAD_W'(win[7]) + GRAD_W'(win[8]));

  assign ax = gx[GRAD_W-1] ? ABS_W'(-gx) : ABS_W'(gx);
  assign ay = gy[GRAD_W-1] ? ABS_W'(-gy) : ABS_W'(gy);

  assign sq_req.start    = (state == S_SUM);
  assign sq_req.radicand = RAD_W'({(SQ_W + 1)'(sqx) + (SQ_W + 1)'(sqy), 8'd0});

  gmag_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (sq_req),
    .done (sq_done),
    .root (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      map_width  <= CFG_W'(4096);
      map_height <= CFG_W'(4096);
      col_cnt    <= '0;
      row_cnt    <= '0;
      m_tvalid   <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_MAP_WIDTH) map_width <= cfg_data;
        if (cfg_index == REG_MAP_HEIGHT) map_height <= cfg_data;
      end
      // the output state reloads the register itself
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MAX_WIDTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            cell_v     <= in_v;
            cur_addr   <= c[AW-1:0];
            has_result <= (c >= WW'(2)) && (r >= ROW_W'(2));
            ctr_col    <= POS_W'(c - WW'(1));
            ctr_row    <= POS_W'(r - ROW_W'(1));
            last_flag  <= (c == eff_w - WW'(1)) && (r == eff_h - ROW_W'(1));
            col_cnt    <= col_next;
            row_cnt    <= row_next;
            state      <= S_READ;
          end
        end
        S_READ: begin
          for (int k = 0; k < 3; k++) begin
            win[k*3]   <= win[k*3+1];
            win[k*3+1] <= win[k*3+2];
          end
          win[2] <= top_v;
          win[5] <= mid_v;
          win[8] <= cell_v;
          state  <= has_result ? S_GRAD : S_IDLE;
        end
        S_GRAD: begin
          gx        <= gx_c;
          gy        <= gy_c;
          centre_ok <= (win[4] > 0);
          state     <= S_SQ;
        end
        S_SQ: begin
          sqx   <= ax * ax;
          sqy   <= ay * ay;
          state <= S_SUM;
        end
        S_SUM: begin
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_done) state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, (centre_ok ? sq_root : MAG_W'(0)),
                         gy, gx, ctr_row, ctr_col};
            m_tuser  <= centre_ok;
            m_tlast  <= last_flag;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // no magnitude leaves for an obstacle or unreached centre
  a_mag_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[72:54] == '0))
    else $error("magnitude nonzero on invalid centre");

  // the root unit finishes only while the sequencer waits on it
  a_sqrt_wait: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == S_SQRT))
    else $error("root finished outside wait state");

  // an accepted cell always goes to the line store access next
  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_READ))
    else $error("accepted cell skipped line store access");

endmodule

`default_nettype wire
